[design/pfa_pkg.sv]
// Shared types, codes and constants of the paged first-fit allocator.
// Used by pfa_ctrl and paged_first_fit_allocator_unit; depends on nothing.
`default_nettype none

package pfa_pkg;

    // Pool geometry, fixed by the widths of the address and size fields.
    localparam int POOL_BYTES = 1024;
    localparam int ALIGN = 4;
    localparam int AW = 10;
    localparam int LW = 11;
    localparam int CW = 12;

    // Defaults of the top-level parameters.
    localparam int DEF_MAX_SEGMENTS = 64;
    localparam int DEF_MAX_PAGES = 16;

    // Reset values of the configuration registers.
    localparam logic [LW-1:0] RST_MAX_REQUEST = 11'd1024;
    localparam logic [LW-1:0] RST_PAGE_SIZE = 11'd100;

    // Configuration register indexes.
    localparam logic CFG_MAX_REQUEST = 1'b0;
    localparam logic CFG_PAGE_SIZE = 1'b1;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE = 2'd1,
        OP_REALLOC = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_POOL_FULL = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FSCAN,
        S_NSCAN,
        S_ACHK,
        S_ASCAN,
        S_W0,
        S_W1,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op op;
        logic [LW-1:0] size;
        logic [AW-1:0] addr;
    } t_req;

    typedef struct packed {
        logic [LW-1:0] max_request;
        logic [LW-1:0] page_size;
    } t_cfg;

    typedef struct packed {
        logic [AW-1:0] addr;
        t_status status;
    } t_rsp;

    typedef struct packed {
        logic idle;
        logic done;
        logic [LW-1:0] next_free;
    } t_stat;

endpackage

`default_nettype wire

[design/pfa_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[design/pfa_ctrl.sv]
// Request sequencer of the allocator: scans the segment memory, decides and writes back.
// Depends on pfa_pkg; drives an external pfa_ram holding {page, start, length}.
`default_nettype none

module pfa_ctrl #(
    parameter int MAX_SEGMENTS = pfa_pkg::DEF_MAX_SEGMENTS,
    parameter int MAX_PAGES = pfa_pkg::DEF_MAX_PAGES,
    localparam int IW = $clog2(MAX_SEGMENTS),
    localparam int PGW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1,
    localparam int EW = PGW + pfa_pkg::AW + pfa_pkg::LW
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire pfa_pkg::t_req   i_req,
    input  wire pfa_pkg::t_cfg   i_cfg,
    input  wire logic            i_rsp_take,
    output pfa_pkg::t_rsp        o_rsp,
    output pfa_pkg::t_stat       o_stat,
    output logic                 o_ram_we,
    output logic [IW-1:0]        o_ram_waddr,
    output logic [EW-1:0]        o_ram_wdata,
    output logic [IW-1:0]        o_ram_raddr,
    input  wire logic [EW-1:0]   i_ram_rdata
);

    localparam int AW = pfa_pkg::AW;
    localparam int LW = pfa_pkg::LW;
    localparam int CW = pfa_pkg::CW;
    localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
    localparam int PCW = $clog2(MAX_PAGES + 1);

    // Control state.
    pfa_pkg::t_state r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic r_rd_vld, n_rd_vld;
    logic [MAX_SEGMENTS-1:0] r_valid, n_valid;
    logic [MAX_SEGMENTS-1:0] r_used, n_used;
    logic [PCW-1:0] r_page_count, n_page_count;
    logic [LW-1:0] r_next_free, n_next_free;
    logic r_in_alloc, n_in_alloc;

    // Payload state.
    pfa_pkg::t_req r_req, n_req;
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic r_hit_f, n_hit_f;
    logic [IW-1:0] r_hit_idx, n_hit_idx;
    logic [LW-1:0] r_hit_len, n_hit_len;
    logic [PGW-1:0] r_hit_page, n_hit_page;
    logic r_nx_f, n_nx_f;
    logic [IW-1:0] r_nx_idx, n_nx_idx;
    logic [LW-1:0] r_nx_len, n_nx_len;
    logic r_pv_f, n_pv_f;
    logic [IW-1:0] r_pv_idx, n_pv_idx;
    logic [AW-1:0] r_pv_start, n_pv_start;
    logic [LW-1:0] r_pv_len, n_pv_len;
    logic r_bf, n_bf;
    logic [IW-1:0] r_b_idx, n_b_idx;
    logic [AW-1:0] r_b_start, n_b_start;
    logic [LW-1:0] r_b_len, n_b_len;
    logic [PGW-1:0] r_b_page, n_b_page;
    logic r_e0f, n_e0f, r_e1f, n_e1f;
    logic [IW-1:0] r_e0, n_e0, r_e1, n_e1;
    logic [IW-1:0] r_w0_addr, n_w0_addr, r_w1_addr, n_w1_addr;
    logic [EW-1:0] r_w0_data, n_w0_data, r_w1_data, n_w1_data;
    logic r_w1_en, n_w1_en;
    pfa_pkg::t_rsp r_rsp, n_rsp;

    // Decoded read word and helpers.
    logic [PGW-1:0] rd_page;
    logic [AW-1:0] rd_start;
    logic [LW-1:0] rd_len;
    logic rd_valid, rd_used;
    logic issuing, scan_end;
    logic [CW-1:0] canon, plen, room;
    logic [LW-1:0] merged_len;
    logic [PGW-1:0] new_page;

    assign rd_page = i_ram_rdata[EW-1 -: PGW];
    assign rd_start = i_ram_rdata[AW+LW-1:LW];
    assign rd_len = i_ram_rdata[LW-1:0];
    assign rd_valid = r_valid[r_rd_idx];
    assign rd_used = r_used[r_rd_idx];
    assign issuing = (r_cnt < CNTW'(MAX_SEGMENTS));
    assign scan_end = !issuing && !r_rd_vld;

    // Size rounded up to the alignment; a zero size counts as one unit.
    assign canon = (r_req.size == '0) ? CW'(pfa_pkg::ALIGN)
        : (({1'b0, r_req.size} + CW'(pfa_pkg::ALIGN - 1)) / CW'(pfa_pkg::ALIGN))
          * CW'(pfa_pkg::ALIGN);
    assign plen = ({1'b0, i_cfg.page_size} > canon) ? {1'b0, i_cfg.page_size} : canon;
    assign room = CW'(pfa_pkg::POOL_BYTES) - {1'b0, r_next_free};
    assign merged_len = r_hit_len + (r_nx_f ? r_nx_len : '0);
    assign new_page = PGW'(r_page_count);

    assign o_ram_raddr = r_cnt[IW-1:0];
    assign o_ram_we = (r_state == pfa_pkg::S_W0) || (r_state == pfa_pkg::S_W1);
    assign o_ram_waddr = (r_state == pfa_pkg::S_W1) ? r_w1_addr : r_w0_addr;
    assign o_ram_wdata = (r_state == pfa_pkg::S_W1) ? r_w1_data : r_w0_data;

    assign o_rsp = r_rsp;
    assign o_stat.idle = (r_state == pfa_pkg::S_IDLE);
    assign o_stat.done = (r_state == pfa_pkg::S_DONE);
    assign o_stat.next_free = r_next_free;

    // Next state and datapath.
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_rd_vld = 1'b0;
        n_rd_idx = r_rd_idx;
        n_valid = r_valid;
        n_used = r_used;
        n_page_count = r_page_count;
        n_next_free = r_next_free;
        n_in_alloc = r_in_alloc;
        n_req = r_req;
        n_hit_f = r_hit_f;
        n_hit_idx = r_hit_idx;
        n_hit_len = r_hit_len;
        n_hit_page = r_hit_page;
        n_nx_f = r_nx_f;
        n_nx_idx = r_nx_idx;
        n_nx_len = r_nx_len;
        n_pv_f = r_pv_f;
        n_pv_idx = r_pv_idx;
        n_pv_start = r_pv_start;
        n_pv_len = r_pv_len;
        n_bf = r_bf;
        n_b_idx = r_b_idx;
        n_b_start = r_b_start;
        n_b_len = r_b_len;
        n_b_page = r_b_page;
        n_e0f = r_e0f;
        n_e0 = r_e0;
        n_e1f = r_e1f;
        n_e1 = r_e1;
        n_w0_addr = r_w0_addr;
        n_w0_data = r_w0_data;
        n_w1_addr = r_w1_addr;
        n_w1_data = r_w1_data;
        n_w1_en = r_w1_en;
        n_rsp = r_rsp;

        // Scan states step the read address and line up the index with the data.
        if (r_state == pfa_pkg::S_FSCAN || r_state == pfa_pkg::S_NSCAN ||
            r_state == pfa_pkg::S_ASCAN) begin
            n_rd_vld = issuing;
            n_rd_idx = r_cnt[IW-1:0];
            if (issuing) begin
                n_cnt = r_cnt + CNTW'(1);
            end
        end

        case (r_state)
            pfa_pkg::S_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    n_in_alloc = 1'b0;
                    n_cnt = '0;
                    n_hit_f = 1'b0;
                    n_rsp.addr = '0;
                    n_rsp.status = pfa_pkg::ST_OK;
                    case (i_req.op)
                        pfa_pkg::OP_ALLOC: begin
                            n_in_alloc = 1'b1;
                            n_state = pfa_pkg::S_ACHK;
                        end
                        pfa_pkg::OP_FREE, pfa_pkg::OP_REALLOC: begin
                            // Pages tile the pool from zero, so an offset at or past
                            // the fill mark has no owning page.
                            if ({1'b0, i_req.addr} >= r_next_free) begin
                                if (i_req.op == pfa_pkg::OP_FREE) begin
                                    n_rsp.status = pfa_pkg::ST_NOT_FOUND;
                                    n_state = pfa_pkg::S_DONE;
                                end else begin
                                    n_in_alloc = 1'b1;
                                    n_state = pfa_pkg::S_ACHK;
                                end
                            end else begin
                                n_state = pfa_pkg::S_FSCAN;
                            end
                        end
                        default: begin
                            n_state = pfa_pkg::S_DONE;
                        end
                    endcase
                end
            end

            // Find the used segment that starts at the given offset.
            pfa_pkg::S_FSCAN: begin
                if (r_rd_vld && rd_valid && rd_used && !r_hit_f && rd_start == r_req.addr) begin
                    n_hit_f = 1'b1;
                    n_hit_idx = r_rd_idx;
                    n_hit_len = rd_len;
                    n_hit_page = rd_page;
                end
                if (scan_end) begin
                    if (!r_hit_f) begin
                        if (r_req.op == pfa_pkg::OP_FREE) begin
                            n_rsp.status = pfa_pkg::ST_NOT_FOUND;
                            n_state = pfa_pkg::S_DONE;
                        end else begin
                            n_in_alloc = 1'b1;
                            n_state = pfa_pkg::S_ACHK;
                        end
                    end else begin
                        n_used[r_hit_idx] = 1'b0;
                        n_cnt = '0;
                        n_nx_f = 1'b0;
                        n_pv_f = 1'b0;
                        n_state = pfa_pkg::S_NSCAN;
                    end
                end
            end

            // Look for free neighbors in the same page on both sides.
            pfa_pkg::S_NSCAN: begin
                if (r_rd_vld && rd_valid && !rd_used && r_rd_idx != r_hit_idx &&
                    rd_page == r_hit_page) begin
                    if ({1'b0, rd_start} == ({1'b0, r_req.addr} + r_hit_len) && !r_nx_f) begin
                        n_nx_f = 1'b1;
                        n_nx_idx = r_rd_idx;
                        n_nx_len = rd_len;
                    end
                    if (({1'b0, rd_start} + rd_len) == {1'b0, r_req.addr} && !r_pv_f) begin
                        n_pv_f = 1'b1;
                        n_pv_idx = r_rd_idx;
                        n_pv_start = rd_start;
                        n_pv_len = rd_len;
                    end
                end
                if (scan_end) begin
                    if (r_nx_f) begin
                        n_valid[r_nx_idx] = 1'b0;
                    end
                    if (r_pv_f) begin
                        n_valid[r_hit_idx] = 1'b0;
                        n_w0_addr = r_pv_idx;
                        n_w0_data = {r_hit_page, r_pv_start, r_pv_len + merged_len};
                    end else begin
                        n_w0_addr = r_hit_idx;
                        n_w0_data = {r_hit_page, r_req.addr, merged_len};
                    end
                    n_w1_en = 1'b0;
                    n_state = pfa_pkg::S_W0;
                end
            end

            // Size check before the fit search.
            pfa_pkg::S_ACHK: begin
                n_rsp.addr = '0;
                if (r_req.size > i_cfg.max_request) begin
                    n_rsp.status = pfa_pkg::ST_TOO_LARGE;
                    n_state = pfa_pkg::S_DONE;
                end else begin
                    n_cnt = '0;
                    n_bf = 1'b0;
                    n_e0f = 1'b0;
                    n_e1f = 1'b0;
                    n_state = pfa_pkg::S_ASCAN;
                end
            end

            // Lowest-addressed free segment that fits; pages rise in address with
            // creation order, so this is also the first page that fits.
            pfa_pkg::S_ASCAN: begin
                if (r_rd_vld) begin
                    if (rd_valid) begin
                        if (!rd_used && {1'b0, rd_len} >= canon &&
                            (!r_bf || rd_start < r_b_start)) begin
                            n_bf = 1'b1;
                            n_b_idx = r_rd_idx;
                            n_b_start = rd_start;
                            n_b_len = rd_len;
                            n_b_page = rd_page;
                        end
                    end else if (!r_e0f) begin
                        n_e0f = 1'b1;
                        n_e0 = r_rd_idx;
                    end else if (!r_e1f) begin
                        n_e1f = 1'b1;
                        n_e1 = r_rd_idx;
                    end
                end
                if (scan_end) begin
                    n_state = pfa_pkg::S_DONE;
                    n_w1_en = 1'b0;
                    if (r_bf) begin
                        if ({1'b0, r_b_len} > canon) begin
                            if (!r_e0f) begin
                                n_rsp.status = pfa_pkg::ST_TABLE_FULL;
                            end else begin
                                // Carve the front and keep the remainder free.
                                n_used[r_b_idx] = 1'b1;
                                n_valid[r_e0] = 1'b1;
                                n_used[r_e0] = 1'b0;
                                n_w0_addr = r_b_idx;
                                n_w0_data = {r_b_page, r_b_start, canon[LW-1:0]};
                                n_w1_en = 1'b1;
                                n_w1_addr = r_e0;
                                n_w1_data = {r_b_page, r_b_start + canon[AW-1:0],
                                             r_b_len - canon[LW-1:0]};
                                n_rsp.addr = r_b_start;
                                n_state = pfa_pkg::S_W0;
                            end
                        end else begin
                            n_used[r_b_idx] = 1'b1;
                            n_rsp.addr = r_b_start;
                        end
                    end else if (r_page_count >= PCW'(MAX_PAGES)) begin
                        n_rsp.status = pfa_pkg::ST_TABLE_FULL;
                    end else if (plen > room) begin
                        n_rsp.status = pfa_pkg::ST_POOL_FULL;
                    end else if (!r_e0f || (plen > canon && !r_e1f)) begin
                        n_rsp.status = pfa_pkg::ST_TABLE_FULL;
                    end else begin
                        // Open a new page at the fill mark.
                        n_valid[r_e0] = 1'b1;
                        n_used[r_e0] = 1'b1;
                        n_w0_addr = r_e0;
                        n_w0_data = {new_page, r_next_free[AW-1:0], canon[LW-1:0]};
                        if (plen > canon) begin
                            n_valid[r_e1] = 1'b1;
                            n_used[r_e1] = 1'b0;
                            n_w1_en = 1'b1;
                            n_w1_addr = r_e1;
                            n_w1_data = {new_page, r_next_free[AW-1:0] + canon[AW-1:0],
                                         plen[LW-1:0] - canon[LW-1:0]};
                        end
                        n_page_count = r_page_count + PCW'(1);
                        n_next_free = r_next_free + plen[LW-1:0];
                        n_rsp.addr = r_next_free[AW-1:0];
                        n_state = pfa_pkg::S_W0;
                    end
                end
            end

            pfa_pkg::S_W0, pfa_pkg::S_W1: begin
                if (r_state == pfa_pkg::S_W0 && r_w1_en) begin
                    n_state = pfa_pkg::S_W1;
                end else if (!r_in_alloc && r_req.op == pfa_pkg::OP_REALLOC) begin
                    n_in_alloc = 1'b1;
                    n_state = pfa_pkg::S_ACHK;
                end else begin
                    n_state = pfa_pkg::S_DONE;
                end
            end

            // Hold the result until the output register can take it.
            pfa_pkg::S_DONE: begin
                if (i_rsp_take) begin
                    n_state = pfa_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = pfa_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfa_pkg::S_IDLE;
            r_cnt <= '0;
            r_rd_vld <= 1'b0;
            r_valid <= '0;
            r_used <= '0;
            r_page_count <= '0;
            r_next_free <= '0;
            r_in_alloc <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_rd_vld <= n_rd_vld;
            r_valid <= n_valid;
            r_used <= n_used;
            r_page_count <= n_page_count;
            r_next_free <= n_next_free;
            r_in_alloc <= n_in_alloc;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_rd_idx <= n_rd_idx;
        r_hit_f <= n_hit_f;
        r_hit_idx <= n_hit_idx;
        r_hit_len <= n_hit_len;
        r_hit_page <= n_hit_page;
        r_nx_f <= n_nx_f;
        r_nx_idx <= n_nx_idx;
        r_nx_len <= n_nx_len;
        r_pv_f <= n_pv_f;
        r_pv_idx <= n_pv_idx;
        r_pv_start <= n_pv_start;
        r_pv_len <= n_pv_len;
        r_bf <= n_bf;
        r_b_idx <= n_b_idx;
        r_b_start <= n_b_start;
        r_b_len <= n_b_len;
        r_b_page <= n_b_page;
        r_e0f <= n_e0f;
        r_e0 <= n_e0;
        r_e1f <= n_e1f;
        r_e1 <= n_e1;
        r_w0_addr <= n_w0_addr;
        r_w0_data <= n_w0_data;
        r_w1_addr <= n_w1_addr;
        r_w1_data <= n_w1_data;
        r_w1_en <= n_w1_en;
        r_rsp <= n_rsp;
    end

endmodule

`default_nettype wire

[design/paged_first_fit_allocator_unit.sv]
// Top level of the paged first-fit allocator: configuration, channels, output word.
// Depends on pfa_pkg, pfa_ram and pfa_ctrl.
//
// A request word (op, req_size, block_addr) is taken on i_req_valid/o_req_ready; one
// response word (result_addr, status) leaves on o_rsp_valid/i_rsp_ready for each.
// Requests are handled one at a time. The segment table sits in one memory and every
// pass over it reads all MAX_SEGMENTS entries, so the memory read port sets the rate.
// An allocate makes one pass over the table. A free makes one pass to find the used
// segment that starts at the offset and a second for its free neighbours, or only the
// first when no used segment starts there. A reallocate runs the free part when the
// offset lies below the fill mark, and then an allocate. A too-large allocate and a free
// of an offset past the fill mark are answered without a pass over the table.
// The response word becomes valid in the same cycle as the next request can be taken.
// The response sits in an output register; the next request is taken while it waits,
// and a finished request waits for that register to be taken before the next one.
// Reset empties the table (valid bits in flip-flops, no clearing pass), sets the
// page count and fill mark to zero, and loads max_request = 1024, page_size = 100.
// Configuration writes are registered and are meant for idle periods only.
`default_nettype none

module paged_first_fit_allocator_unit #(
    parameter int MAX_SEGMENTS = pfa_pkg::DEF_MAX_SEGMENTS,
    parameter int MAX_PAGES = pfa_pkg::DEF_MAX_PAGES
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_req_valid,
    output logic                         o_req_ready,
    input  wire logic [1:0]              i_op,
    input  wire logic [pfa_pkg::LW-1:0]  i_req_size,
    input  wire logic [pfa_pkg::AW-1:0]  i_block_addr,
    output logic                         o_rsp_valid,
    input  wire logic                    i_rsp_ready,
    output logic [pfa_pkg::AW-1:0]       o_result_addr,
    output logic [2:0]                   o_status,
    input  wire logic                    i_cfg_we,
    input  wire logic                    i_cfg_idx,
    input  wire logic [pfa_pkg::LW-1:0]  i_cfg_data
);

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int PGW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int EW = PGW + pfa_pkg::AW + pfa_pkg::LW;

    pfa_pkg::t_cfg r_cfg;
    logic r_rsp_valid;
    pfa_pkg::t_rsp r_rsp;
    pfa_pkg::t_req req;
    pfa_pkg::t_rsp ctrl_rsp;
    pfa_pkg::t_stat stat;
    logic start, rsp_take;
    logic ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    assign req.op = pfa_pkg::t_op'(i_op);
    assign req.size = i_req_size;
    assign req.addr = i_block_addr;
    assign o_req_ready = stat.idle;
    assign start = i_req_valid && o_req_ready;
    assign rsp_take = !r_rsp_valid || i_rsp_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_request <= pfa_pkg::RST_MAX_REQUEST;
            r_cfg.page_size <= pfa_pkg::RST_PAGE_SIZE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pfa_pkg::CFG_MAX_REQUEST: r_cfg.max_request <= i_cfg_data;
                pfa_pkg::CFG_PAGE_SIZE: r_cfg.page_size <= i_cfg_data;
                default: r_cfg.page_size <= i_cfg_data;
            endcase
        end
    end

    // Output register between the sequencer and the receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (stat.done && rsp_take) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.done && rsp_take) begin
            r_rsp <= ctrl_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_result_addr = r_rsp.addr;
    assign o_status = r_rsp.status;

    pfa_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_SEGMENTS)
    ) u_seg_ram (
        .i_clk(i_clk),
        .i_we(ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    pfa_ctrl #(
        .MAX_SEGMENTS(MAX_SEGMENTS),
        .MAX_PAGES(MAX_PAGES)
    ) u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_req(req),
        .i_cfg(r_cfg),
        .i_rsp_take(rsp_take),
        .o_rsp(ctrl_rsp),
        .o_stat(stat),
        .o_ram_we(ram_we),
        .o_ram_waddr(ram_waddr),
        .o_ram_wdata(ram_wdata),
        .o_ram_raddr(ram_raddr),
        .i_ram_rdata(ram_rdata)
    );

    // A taken request keeps the input closed until it has been answered.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request accepted while another was in flight");

    // Every failing response carries a zero offset.
    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_status != pfa_pkg::ST_OK |-> o_result_addr == '0)
        else $error("failed response with a nonzero offset");

    // The fill mark never runs past the pool.
    a_fill_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.next_free <= pfa_pkg::LW'(pfa_pkg::POOL_BYTES))
        else $error("fill mark beyond the pool");

endmodule

`default_nettype wire
